### src/date_time_set_editor_core_defines.svh
// Assertion macros shared by the editor core.
`ifndef DATE_TIME_SET_EDITOR_CORE_DEFINES_SVH
`define DATE_TIME_SET_EDITOR_CORE_DEFINES_SVH

// Checks an implication in the same cycle, outside of reset.
`define DTSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks an implication in the next cycle, outside of reset.
`define DTSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dtse_pkg.sv
package dtse_pkg;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_DEC  = 2'd1;
  localparam logic [1:0] CMD_INC  = 2'd2;
  localparam logic [1:0] CMD_NEXT = 2'd3;

  localparam logic [2:0] SEL_YEAR   = 3'd0;
  localparam logic [2:0] SEL_MONTH  = 3'd1;
  localparam logic [2:0] SEL_DAY    = 3'd2;
  localparam logic [2:0] SEL_HOUR   = 3'd3;
  localparam logic [2:0] SEL_MINUTE = 3'd4;
  localparam logic [2:0] SEL_SECOND = 3'd5;

  localparam logic [6:0] YEAR_OFF_MAX = 7'd99;
  localparam logic [3:0] MONTH_MIN    = 4'd1;
  localparam logic [3:0] MONTH_MAX    = 4'd12;
  localparam logic [3:0] MONTH_MAR    = 4'd3;
  localparam logic [3:0] MONTH_FEB    = 4'd2;
  localparam logic [4:0] DAY_MIN      = 5'd1;
  localparam logic [4:0] DAY_MAX      = 5'd31;
  localparam logic [4:0] DAY_LEAP_FEB = 5'd29;
  localparam logic [4:0] HOUR_MAX     = 5'd23;
  localparam logic [5:0] MINSEC_MAX   = 6'd59;

  localparam logic [6:0] RST_YEAR   = 7'd26;
  localparam logic [3:0] RST_MONTH  = 4'd8;
  localparam logic [4:0] RST_DAY    = 5'd15;
  localparam logic [4:0] RST_HOUR   = 5'd15;
  localparam logic [5:0] RST_MINUTE = 6'd30;
  localparam logic [5:0] RST_SECOND = 6'd0;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [2:0] SAK_TAB [12] = '{
    3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3,
    3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
  };

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } dtse_item_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } dtse_vals_t;

  function automatic logic [3:0] mon_idx(input logic [3:0] m);
    logic [3:0] r;
    if (m < MONTH_MIN) begin
      r = 4'd0;
    end else if (m > MONTH_MAX) begin
      r = 4'd11;
    end else begin
      r = m - 4'd1;
    end
    return r;
  endfunction

  // Every year from 2000 to 2099 that is a multiple of four is a leap year.
  function automatic logic [4:0] month_days(input logic [6:0] yoff, input logic [3:0] m);
    logic [4:0] r;
    if (m == MONTH_FEB && yoff[1:0] == 2'd0) begin
      r = DAY_LEAP_FEB;
    end else begin
      r = MONTH_LEN[mon_idx(m)];
    end
    return r;
  endfunction

  // Since 64 and 8 are both one more than a multiple of seven, the digits fold.
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [6:0] r1;
    logic [4:0] r2;
    logic [3:0] r3;
    r1 = {5'd0, x[7:6]} + {1'b0, x[5:0]};
    r2 = {1'b0, r1[6:3]} + {2'd0, r1[2:0]};
    r3 = {2'd0, r2[4:3]} + {1'b0, r2[2:0]};
    if (r3 >= 4'd7) begin
      r3 = r3 - 4'd7;
    end
    return r3[2:0];
  endfunction

endpackage

### src/dtse_in_reg.sv
module dtse_in_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dtse_pkg::dtse_item_t  in_item,
  input  logic                  adv,
  output logic                  vld,
  output dtse_pkg::dtse_item_t  item
);
  import dtse_pkg::*;

  logic       vld_r;
  logic       vld_nxt;
  dtse_item_t item_r;

  assign in_ready = !vld_r || adv;
  assign vld_nxt  = (in_valid && in_ready) || (vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

### src/dtse_update.sv
module dtse_update (
  input  dtse_pkg::dtse_item_t item,
  input  dtse_pkg::dtse_vals_t cur,
  input  logic [2:0]           field,
  output dtse_pkg::dtse_vals_t vals_nxt,
  output logic [2:0]           field_nxt,
  output logic                 committed
);
  import dtse_pkg::*;

  function automatic logic [6:0] step_val(input logic [6:0] v, input logic up,
                                          input logic [6:0] lo, input logic [6:0] hi);
    logic [6:0] r;
    r = v;
    if (up) begin
      if (v < hi) begin
        r = v + 7'd1;
      end
    end else begin
      if (v > lo) begin
        r = v - 7'd1;
      end
    end
    return r;
  endfunction

  logic       up;
  logic [4:0] cur_dim;

  assign up      = (item.cmd == CMD_INC);
  assign cur_dim = month_days(cur.year, cur.month);

  always_comb begin
    vals_nxt  = cur;
    field_nxt = field;
    committed = 1'b0;
    unique case (item.cmd)
      CMD_LOAD: begin
        vals_nxt.year   = (item.year > YEAR_OFF_MAX) ? YEAR_OFF_MAX : item.year;
        vals_nxt.month  = (item.month < MONTH_MIN) ? MONTH_MIN :
                          (item.month > MONTH_MAX) ? MONTH_MAX : item.month;
        vals_nxt.day    = (item.day < DAY_MIN) ? DAY_MIN : item.day;
        vals_nxt.hour   = (item.hour > HOUR_MAX) ? HOUR_MAX : item.hour;
        vals_nxt.minute = (item.minute > MINSEC_MAX) ? MINSEC_MAX : item.minute;
        vals_nxt.second = (item.second > MINSEC_MAX) ? MINSEC_MAX : item.second;
        field_nxt       = SEL_YEAR;
      end
      CMD_DEC, CMD_INC: begin
        unique case (field)
          SEL_YEAR: begin
            vals_nxt.year = step_val(cur.year, up, 7'd0, YEAR_OFF_MAX);
          end
          SEL_MONTH: begin
            vals_nxt.month = 4'(step_val({3'd0, cur.month}, up, {3'd0, MONTH_MIN},
                                         {3'd0, MONTH_MAX}));
          end
          SEL_DAY: begin
            vals_nxt.day = 5'(step_val({2'd0, cur.day}, up, {2'd0, DAY_MIN},
                                       {2'd0, cur_dim}));
          end
          SEL_HOUR: begin
            vals_nxt.hour = 5'(step_val({2'd0, cur.hour}, up, 7'd0, {2'd0, HOUR_MAX}));
          end
          SEL_MINUTE: begin
            vals_nxt.minute = 6'(step_val({1'b0, cur.minute}, up, 7'd0,
                                          {1'b0, MINSEC_MAX}));
          end
          SEL_SECOND: begin
            vals_nxt.second = 6'(step_val({1'b0, cur.second}, up, 7'd0,
                                          {1'b0, MINSEC_MAX}));
          end
          default: begin
          end
        endcase
        if (vals_nxt.day > month_days(vals_nxt.year, vals_nxt.month)) begin
          vals_nxt.day = month_days(vals_nxt.year, vals_nxt.month);
        end
      end
      CMD_NEXT: begin
        if (field >= SEL_SECOND) begin
          field_nxt = SEL_SECOND;
          committed = 1'b1;
        end else begin
          field_nxt = field + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### src/dtse_weekday.sv
module dtse_weekday (
  input  dtse_pkg::dtse_vals_t vals,
  output logic [2:0]           weekday
);
  import dtse_pkg::*;

  // With t the year offset, less one in January and February, the year terms
  // reduce to t + floor(t / 4) plus a constant that is a multiple of seven.
  logic       early;
  logic [7:0] t;
  logic [7:0] tq;
  logic [7:0] sum;

  assign early   = (vals.month < MONTH_MAR);
  assign t       = {1'b0, vals.year} - {7'd0, early};
  assign tq      = {{2{t[7]}}, t[7:2]};
  assign sum     = t + tq + {5'd0, SAK_TAB[mon_idx(vals.month)]} + {3'd0, vals.day} + 8'd7;
  assign weekday = mod7(sum);

endmodule

### src/date_time_set_editor_core.sv
// Date and time editor core, driven by key events.
// Input channel (in_valid/in_ready): one key event per transfer with a command
// (load, decrement, increment, next) and the clock's present date and time,
// which only the load command uses.
// Result channel (out_valid/out_ready): one result per event with the selected
// field, the edited date and time, the weekday, and a commit flag that is set
// when next is pressed on the seconds field.
// An event waits in the input register; when the result register is free or its
// result is being taken, the update and weekday logic load the edit state and
// the result register, which raises out_valid. Throughput is one event per cycle
// while the receiver does not stall; the edit state feeds its own update through
// combinational logic.
// When the receiver stalls, the pending result holds and the input register
// can still take one more event, after which in_ready drops until the result
// is taken.
// Reset is synchronous and active low: both channels go empty, the year field
// is selected and the edit state returns to its power-on date and time.
`include "date_time_set_editor_core_defines.svh"

module date_time_set_editor_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [6:0] in_load_year_offset,
  input  logic [3:0] in_load_month,
  input  logic [4:0] in_load_day,
  input  logic [4:0] in_load_hour,
  input  logic [5:0] in_load_minute,
  input  logic [5:0] in_load_second,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_committed,
  output logic [2:0] out_selected_field,
  output logic [6:0] out_year_offset,
  output logic [3:0] out_month,
  output logic [4:0] out_day,
  output logic [4:0] out_hour,
  output logic [5:0] out_minute,
  output logic [5:0] out_second,
  output logic [2:0] out_weekday
);
  import dtse_pkg::*;

  dtse_item_t in_item;
  dtse_item_t item;
  logic       item_vld;
  logic       adv;

  dtse_vals_t vals_r;
  dtse_vals_t vals_nxt;
  logic [2:0] field_r;
  logic [2:0] field_nxt;
  logic       committed_nxt;
  logic       committed_r;
  logic [2:0] weekday_nxt;
  logic [2:0] weekday_r;
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic       date_ok;

  assign in_item.cmd    = in_command;
  assign in_item.year   = in_load_year_offset;
  assign in_item.month  = in_load_month;
  assign in_item.day    = in_load_day;
  assign in_item.hour   = in_load_hour;
  assign in_item.minute = in_load_minute;
  assign in_item.second = in_load_second;

  assign adv = item_vld && (!out_vld_r || out_ready);

  dtse_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .adv      (adv),
    .vld      (item_vld),
    .item     (item)
  );

  dtse_update u_update (
    .item      (item),
    .cur       (vals_r),
    .field     (field_r),
    .vals_nxt  (vals_nxt),
    .field_nxt (field_nxt),
    .committed (committed_nxt)
  );

  dtse_weekday u_weekday (
    .vals    (vals_nxt),
    .weekday (weekday_nxt)
  );

  assign out_vld_nxt = adv || (out_vld_r && !out_ready);

  // The edit state only changes when a result is loaded, so it doubles as the
  // held result payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r     <= 1'b0;
      field_r       <= SEL_YEAR;
      vals_r.year   <= RST_YEAR;
      vals_r.month  <= RST_MONTH;
      vals_r.day    <= RST_DAY;
      vals_r.hour   <= RST_HOUR;
      vals_r.minute <= RST_MINUTE;
      vals_r.second <= RST_SECOND;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        field_r <= field_nxt;
        vals_r  <= vals_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      committed_r <= committed_nxt;
      weekday_r   <= weekday_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_committed      = committed_r;
  assign out_selected_field = field_r;
  assign out_year_offset    = vals_r.year;
  assign out_month          = vals_r.month;
  assign out_day            = vals_r.day;
  assign out_hour           = vals_r.hour;
  assign out_minute         = vals_r.minute;
  assign out_second         = vals_r.second;
  assign out_weekday        = weekday_r;

  assign date_ok = vals_r.day != 5'd0 && vals_r.month >= MONTH_MIN &&
                   vals_r.month <= MONTH_MAX && weekday_r <= 3'd6;

  `DTSE_ASSERT_NOW(a_commit_on_second, out_vld_r && committed_r, field_r == SEL_SECOND, "bad commit")
  `DTSE_ASSERT_NOW(a_ready_when_free, !out_vld_r || out_ready, in_ready, "in_ready low")
  `DTSE_ASSERT_NOW(a_date_range, out_vld_r, date_ok, "edited date out of range")
  `DTSE_ASSERT_NEXT(a_advance_loads, adv, out_vld_r, "event lost on the way out")

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dtse_pkg::*;

  typedef struct packed {
    logic       committed;
    logic [2:0] field;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } edit_result_t;

  typedef struct {
    dtse_item_t   key;
    bit           typed;
    edit_result_t want;
  } script_row_t;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int DRAIN_CYCLES     = 8;
  localparam int MAX_REPORTS      = 60;

  localparam int MONTH_SPAN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int MONTH_KEY [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_command = CMD_LOAD;
  logic [6:0] in_load_year_offset = '0;
  logic [3:0] in_load_month = '0;
  logic [4:0] in_load_day = '0;
  logic [4:0] in_load_hour = '0;
  logic [5:0] in_load_minute = '0;
  logic [5:0] in_load_second = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_committed;
  logic [2:0] out_selected_field;
  logic [6:0] out_year_offset;
  logic [3:0] out_month;
  logic [4:0] out_day;
  logic [4:0] out_hour;
  logic [5:0] out_minute;
  logic [5:0] out_second;
  logic [2:0] out_weekday;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int error_count = 0;
  int keys_sent = 0;
  int loads_sent = 0;
  int results_checked = 0;
  int commits_seen = 0;

  int ed_field = 0;
  int ed_year = 26;
  int ed_month = 8;
  int ed_day = 15;
  int ed_hour = 15;
  int ed_minute = 30;
  int ed_second = 0;

  edit_result_t expected_results[$];
  script_row_t  key_script[$];

  date_time_set_editor_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_load_year_offset (in_load_year_offset),
    .in_load_month       (in_load_month),
    .in_load_day         (in_load_day),
    .in_load_hour        (in_load_hour),
    .in_load_minute      (in_load_minute),
    .in_load_second      (in_load_second),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_committed       (out_committed),
    .out_selected_field  (out_selected_field),
    .out_year_offset     (out_year_offset),
    .out_month           (out_month),
    .out_day             (out_day),
    .out_hour            (out_hour),
    .out_minute          (out_minute),
    .out_second          (out_second),
    .out_weekday         (out_weekday)
  );

  always #1 clk = ~clk;

  function automatic int month_length(input int yoff, input int m);
    int  y = 2000 + yoff;
    bit  leap;
    leap = ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    if (m == 2 && leap) begin
      return 29;
    end
    return MONTH_SPAN[m - 1];
  endfunction

  function automatic int weekday_of(input int yoff, input int m, input int d);
    int y = 2000 + yoff;
    if (m < 3) begin
      y = y - 1;
    end
    return (y + y / 4 - y / 100 + y / 400 + MONTH_KEY[m - 1] + d) % 7;
  endfunction

  function automatic int bump(input int v, input bit up, input int lo, input int hi);
    if (up && v < hi) begin
      return v + 1;
    end else if (!up && v > lo) begin
      return v - 1;
    end
    return v;
  endfunction

  function automatic edit_result_t predict_edit(input dtse_item_t key);
    edit_result_t r;
    bit           up;
    int           limit;
    r.committed = 1'b0;
    case (key.cmd)
      CMD_LOAD: begin
        ed_year = (key.year > YEAR_OFF_MAX) ? 99 : int'(key.year);
        ed_month = (key.month < 1) ? 1 : (key.month > 12) ? 12 : int'(key.month);
        ed_day = (key.day == 0) ? 1 : int'(key.day);
        ed_hour = (key.hour > 23) ? 23 : int'(key.hour);
        ed_minute = (key.minute > 59) ? 59 : int'(key.minute);
        ed_second = (key.second > 59) ? 59 : int'(key.second);
        ed_field = int'(SEL_YEAR);
      end
      CMD_DEC, CMD_INC: begin
        up = (key.cmd == CMD_INC);
        case (ed_field)
          int'(SEL_YEAR):   ed_year = bump(ed_year, up, 0, 99);
          int'(SEL_MONTH):  ed_month = bump(ed_month, up, 1, 12);
          int'(SEL_DAY):    ed_day = bump(ed_day, up, 1, month_length(ed_year, ed_month));
          int'(SEL_HOUR):   ed_hour = bump(ed_hour, up, 0, 23);
          int'(SEL_MINUTE): ed_minute = bump(ed_minute, up, 0, 59);
          default:          ed_second = bump(ed_second, up, 0, 59);
        endcase
        limit = month_length(ed_year, ed_month);
        if (ed_day > limit) begin
          ed_day = limit;
        end
      end
      default: begin
        if (ed_field == int'(SEL_SECOND)) begin
          r.committed = 1'b1;
        end else begin
          ed_field = ed_field + 1;
        end
      end
    endcase
    r.field = 3'(ed_field);
    r.year = 7'(ed_year);
    r.month = 4'(ed_month);
    r.day = 5'(ed_day);
    r.hour = 5'(ed_hour);
    r.minute = 6'(ed_minute);
    r.second = 6'(ed_second);
    r.weekday = 3'(weekday_of(ed_year, ed_month, ed_day));
    return r;
  endfunction

  function automatic dtse_item_t random_key();
    dtse_item_t k;
    int         pick;
    k.year = 7'($urandom_range(127));
    k.month = 4'($urandom_range(15));
    k.day = 5'($urandom_range(31));
    k.hour = 5'($urandom_range(31));
    k.minute = 6'($urandom_range(63));
    k.second = 6'($urandom_range(63));
    pick = $urandom_range(99);
    if (pick < 10) begin
      k.cmd = CMD_LOAD;
      k.year = 7'($urandom_range(99));
      k.month = ($urandom_range(2) == 0) ? MONTH_FEB : 4'($urandom_range(12, 1));
      k.day = ($urandom_range(1) == 0) ? 5'($urandom_range(31, 27)) : 5'($urandom_range(31, 1));
      k.hour = 5'($urandom_range(23));
      k.minute = 6'($urandom_range(59));
      k.second = 6'($urandom_range(59));
    end else if (pick < 14) begin
      k.cmd = CMD_LOAD;
    end else if (pick < 42) begin
      k.cmd = CMD_DEC;
    end else if (pick < 70) begin
      k.cmd = CMD_INC;
    end else begin
      k.cmd = CMD_NEXT;
    end
    return k;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input int y, input int m, input int d,
                         input int h, input int mi, input int s,
                         input bit typed, input edit_result_t want);
    script_row_t row;
    row.key = '{cmd, 7'(y), 4'(m), 5'(d), 5'(h), 6'(mi), 6'(s)};
    row.typed = typed;
    row.want = want;
    key_script.push_back(row);
  endtask

  task automatic report(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("Mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic send_key(input dtse_item_t key, input bit typed, input edit_result_t want);
    edit_result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(negedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_command <= key.cmd;
    in_load_year_offset <= key.year;
    in_load_month <= key.month;
    in_load_day <= key.day;
    in_load_hour <= key.hour;
    in_load_minute <= key.minute;
    in_load_second <= key.second;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predicted = predict_edit(key);
    expected_results.push_back(typed ? want : predicted);
    keys_sent++;
    if (key.cmd == CMD_LOAD) begin
      loads_sent++;
    end
    @(negedge clk);
  endtask

  task automatic drain_expected();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    edit_result_t got;
    edit_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_committed, out_selected_field, out_year_offset, out_month, out_day,
              out_hour, out_minute, out_second, out_weekday};
      if (got.committed) begin
        commits_seen++;
      end
      if (expected_results.size() == 0) begin
        report("result transfer with no expectation pending");
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        check_field("committed", got.committed, want.committed);
        check_field("selected_field", got.field, want.field);
        check_field("year_offset", got.year, want.year);
        check_field("month", got.month, want.month);
        check_field("day", got.day, want.day);
        check_field("hour", got.hour, want.hour);
        check_field("minute", got.minute, want.minute);
        check_field("second", got.second, want.second);
        check_field("weekday", got.weekday, want.weekday);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1'b1,
            '{1'b0, SEL_MONTH, 7'd26, 4'd8, 5'd15, 5'd15, 6'd30, 6'd0, 3'd6});
    add_row(CMD_LOAD, 0, 0, 0, 0, 0, 0, 1'b1,
            '{1'b0, SEL_YEAR, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd6});
    add_row(CMD_DEC, 127, 15, 31, 31, 63, 63, 1'b0, '0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_DEC, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_LOAD, 127, 15, 31, 31, 63, 63, 1'b1,
            '{1'b0, SEL_YEAR, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd4});
    add_row(CMD_INC, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_INC, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_INC, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_INC, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1'b1,
            '{1'b1, SEL_SECOND, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd4});
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_LOAD, 1, 2, 31, 5, 6, 7, 1'b0, '0);
    add_row(CMD_DEC, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_INC, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_LOAD, 24, 1, 31, 0, 0, 0, 1'b0, '0);
    add_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_INC, 0, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(CMD_LOAD, 100, 13, 0, 24, 60, 60, 1'b0, '0);

    foreach (key_script[i]) begin
      send_key(key_script[i].key, key_script[i].typed, key_script[i].want);
    end
    drain_expected();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_key(random_key(), 1'b0, '0);
      end
      drain_expected();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d key events including %0d loads; checked %0d results with %0d commits.",
             keys_sent, loads_sent, results_checked, commits_seen);
    $display("Flow control ran without idling, with sender gaps, receiver stalls and both.");
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/dtse_pkg.sv
src/dtse_in_reg.sv
src/dtse_update.sv
src/dtse_weekday.sv
src/date_time_set_editor_core.sv
tb/sv/testbench.sv
